[rtl/core/fct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_W     = 64;
    localparam int NORM_W      = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    localparam logic [1:0] MODE_POINT  = 2'd0;
    localparam logic [1:0] MODE_SPHERE = 2'd1;
    localparam logic [1:0] MODE_BOX    = 2'd2;

    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
    localparam logic [1:0] VERDICT_INSIDE    = 2'd1;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

    // load strobes for the two lane stages
    typedef struct packed {
        logic prod_load;
        logic dist_load;
    } stage_en_t;

endpackage

`default_nettype wire

[rtl/core/fct_plane_file.sv]
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_file (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [fct_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fct_pkg::PLANE_W-1:0]        cfg_wdata,
    output logic      [fct_pkg::PLANE_W-1:0]        plane [fct_pkg::PLANE_COUNT]
);

    logic [fct_pkg::PLANE_W-1:0] plane_reg [fct_pkg::PLANE_COUNT];

    // indexes past the last plane are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fct_pkg::PLANE_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            for (int i = 0; i < fct_pkg::PLANE_COUNT; i++) begin
                if (cfg_index == fct_pkg::CFG_INDEX_W'(i)) begin
                    plane_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    assign plane = plane_reg;

endmodule

`default_nettype wire

[rtl/core/fct_plane_eval.sv]
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_eval #(
    parameter  int COORD_BITS       = fct_pkg::COORD_BITS_DEF,
    parameter  int NORMAL_FRAC_BITS = fct_pkg::NORMAL_FRAC_BITS_DEF,
    localparam int PROD_W           = fct_pkg::NORM_W + COORD_BITS,
    localparam int OFS_W            = fct_pkg::NORM_W + NORMAL_FRAC_BITS,
    localparam int DIST_W           = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2
) (
    input  wire logic                          aclk,
    input  wire fct_pkg::stage_en_t            en,
    input  wire logic [fct_pkg::PLANE_W-1:0]   plane,
    input  wire logic                          is_box,
    input  wire logic signed [COORD_BITS-1:0]  x_a,
    input  wire logic signed [COORD_BITS-1:0]  y_a,
    input  wire logic signed [COORD_BITS-1:0]  z_a,
    input  wire logic signed [COORD_BITS-1:0]  x_b,
    input  wire logic signed [COORD_BITS-1:0]  y_b,
    input  wire logic signed [COORD_BITS-1:0]  z_b,
    output logic signed [DIST_W-1:0]           far_dist,
    output logic signed [DIST_W-1:0]           near_dist
);

    logic signed [fct_pkg::NORM_W-1:0] norm [3];
    logic signed [fct_pkg::NORM_W-1:0] ofs;
    logic signed [COORD_BITS-1:0]      lo_c [3];
    logic signed [COORD_BITS-1:0]      hi_c [3];
    logic signed [COORD_BITS-1:0]      far_c [3];
    logic signed [COORD_BITS-1:0]      near_c [3];

    logic signed [PROD_W-1:0] prod_far_next [3];
    logic signed [PROD_W-1:0] prod_near_next [3];
    logic signed [PROD_W-1:0] prod_far_reg [3];
    logic signed [PROD_W-1:0] prod_near_reg [3];

    logic signed [DIST_W-1:0] ofs_scaled;
    logic signed [DIST_W-1:0] far_dist_next;
    logic signed [DIST_W-1:0] near_dist_next;
    logic signed [DIST_W-1:0] far_dist_reg;
    logic signed [DIST_W-1:0] near_dist_reg;

    assign norm[0] = plane[0*fct_pkg::NORM_W +: fct_pkg::NORM_W];
    assign norm[1] = plane[1*fct_pkg::NORM_W +: fct_pkg::NORM_W];
    assign norm[2] = plane[2*fct_pkg::NORM_W +: fct_pkg::NORM_W];
    assign ofs     = plane[3*fct_pkg::NORM_W +: fct_pkg::NORM_W];

    assign lo_c[0] = x_a;
    assign lo_c[1] = y_a;
    assign lo_c[2] = z_a;
    assign hi_c[0] = x_b;
    assign hi_c[1] = y_b;
    assign hi_c[2] = z_b;

    // box: pick the far vertex by the sign of each normal component,
    // a zero component counts as not positive
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (is_box && !norm[k][fct_pkg::NORM_W-1] && (norm[k] != '0)) begin
                far_c[k]  = hi_c[k];
                near_c[k] = lo_c[k];
            end else if (is_box) begin
                far_c[k]  = lo_c[k];
                near_c[k] = hi_c[k];
            end else begin
                far_c[k]  = lo_c[k];
                near_c[k] = lo_c[k];
            end
            prod_far_next[k]  = PROD_W'(norm[k]) * PROD_W'(far_c[k]);
            prod_near_next[k] = PROD_W'(norm[k]) * PROD_W'(near_c[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.prod_load) begin
            prod_far_reg  <= prod_far_next;
            prod_near_reg <= prod_near_next;
        end
    end

    assign ofs_scaled = DIST_W'(ofs) <<< NORMAL_FRAC_BITS;

    assign far_dist_next = DIST_W'(prod_far_reg[0]) + DIST_W'(prod_far_reg[1])
                         + DIST_W'(prod_far_reg[2]) + ofs_scaled;
    assign near_dist_next = DIST_W'(prod_near_reg[0]) + DIST_W'(prod_near_reg[1])
                          + DIST_W'(prod_near_reg[2]) + ofs_scaled;

    always_ff @(posedge aclk) begin
        if (en.dist_load) begin
            far_dist_reg  <= far_dist_next;
            near_dist_reg <= near_dist_next;
        end
    end

    assign far_dist  = far_dist_reg;
    assign near_dist = near_dist_reg;

endmodule

`default_nettype wire

[rtl/core/fct_verdict.sv]
`timescale 1ns / 1ps
`default_nettype none

module fct_verdict #(
    parameter  int COORD_BITS       = fct_pkg::COORD_BITS_DEF,
    parameter  int NORMAL_FRAC_BITS = fct_pkg::NORMAL_FRAC_BITS_DEF,
    localparam int PROD_W           = fct_pkg::NORM_W + COORD_BITS,
    localparam int OFS_W            = fct_pkg::NORM_W + NORMAL_FRAC_BITS,
    localparam int DIST_W           = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2
) (
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic [1:0]                 mode,
    input  wire logic [COORD_BITS-2:0]      radius,
    input  wire logic signed [DIST_W-1:0]   far_dist [fct_pkg::PLANE_COUNT],
    input  wire logic signed [DIST_W-1:0]   near_dist [fct_pkg::PLANE_COUNT],
    output logic [1:0]                      verdict
);

    logic signed [DIST_W-1:0]          rad_pos;
    logic signed [DIST_W-1:0]          rad_neg;
    logic [fct_pkg::PLANE_COUNT-1:0]   out_hit;
    logic [fct_pkg::PLANE_COUNT-1:0]   cross_hit;
    logic [1:0]                        verdict_next;
    logic [1:0]                        verdict_reg;

    assign rad_pos = DIST_W'(radius) <<< NORMAL_FRAC_BITS;
    assign rad_neg = -rad_pos;

    always_comb begin
        for (int i = 0; i < fct_pkg::PLANE_COUNT; i++) begin
            case (mode)
                fct_pkg::MODE_SPHERE: begin
                    out_hit[i]   = far_dist[i] < rad_neg;
                    cross_hit[i] = far_dist[i] < rad_pos;
                end
                fct_pkg::MODE_BOX: begin
                    out_hit[i]   = far_dist[i][DIST_W-1];
                    cross_hit[i] = near_dist[i][DIST_W-1];
                end
                default: begin
                    // point test, also the unused mode code
                    out_hit[i]   = far_dist[i][DIST_W-1];
                    cross_hit[i] = 1'b0;
                end
            endcase
        end

        if (|out_hit) begin
            verdict_next = fct_pkg::VERDICT_OUTSIDE;
        end else if (|cross_hit) begin
            verdict_next = fct_pkg::VERDICT_INTERSECT;
        end else begin
            verdict_next = fct_pkg::VERDICT_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            verdict_reg <= verdict_next;
        end
    end

    assign verdict = verdict_reg;

endmodule

`default_nettype wire

[rtl/core/frustum_cull_test.sv]
// Frustum culling test: classifies a point, a sphere or an axis-aligned box
// against six planes held in configuration registers.
//
// Configuration: write plane k (0 left, 1 right, 2 bottom, 3 top, 4 far,
// 5 near) with cfg_we high, cfg_index = k and cfg_wdata = {d, nz, ny, nx},
// 16 bits each. Indexes above 5 are ignored. Write only while no test is
// in flight.
//
// Input channel s_*: one test per transaction (mode, box/center corners,
// radius). Result channel m_*: one verdict per test, 0 outside, 1 inside,
// 2 intersecting, in input order.
//
// Path: a test passes through the input register, product register,
// distance register and verdict register in that order. Throughput: one
// test per cycle while m_ready is high, set by the four-stage pipeline
// of 36 parallel 16 x COORD_BITS multipliers.
// When m_ready is low, stages hold and bubbles are squeezed out; s_ready
// drops only once all four stages hold a transaction.
// Reset clears all planes to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_test #(
    parameter int COORD_BITS       = fct_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = fct_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_we,
    input  wire logic [fct_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fct_pkg::PLANE_W-1:0]        cfg_wdata,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_mode,
    input  wire logic signed [COORD_BITS-1:0]       s_x_a,
    input  wire logic signed [COORD_BITS-1:0]       s_y_a,
    input  wire logic signed [COORD_BITS-1:0]       s_z_a,
    input  wire logic signed [COORD_BITS-1:0]       s_x_b,
    input  wire logic signed [COORD_BITS-1:0]       s_y_b,
    input  wire logic signed [COORD_BITS-1:0]       s_z_b,
    input  wire logic [COORD_BITS-2:0]              s_radius,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_verdict
);

    localparam int PROD_W = fct_pkg::NORM_W + COORD_BITS;
    localparam int OFS_W  = fct_pkg::NORM_W + NORMAL_FRAC_BITS;
    localparam int DIST_W = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;
    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] stage_load;

    logic [1:0]                   mode0_reg;
    logic signed [COORD_BITS-1:0] x_a_reg, y_a_reg, z_a_reg;
    logic signed [COORD_BITS-1:0] x_b_reg, y_b_reg, z_b_reg;
    logic [COORD_BITS-2:0]        radius0_reg;
    logic [1:0]                   mode1_reg;
    logic [COORD_BITS-2:0]        radius1_reg;
    logic [1:0]                   mode2_reg;
    logic [COORD_BITS-2:0]        radius2_reg;

    logic [fct_pkg::PLANE_W-1:0] plane [fct_pkg::PLANE_COUNT];
    logic signed [DIST_W-1:0]    far_dist [fct_pkg::PLANE_COUNT];
    logic signed [DIST_W-1:0]    near_dist [fct_pkg::PLANE_COUNT];
    fct_pkg::stage_en_t          lane_en;
    logic                        is_box;

    // a stage takes new data when it is empty or its successor moves on
    always_comb begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        stage_load[0] = stage_ready[0] && s_valid;
        valid_next[0] = stage_ready[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            stage_load[k] = stage_ready[k] && valid_reg[k-1];
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            mode0_reg   <= s_mode;
            x_a_reg     <= s_x_a;
            y_a_reg     <= s_y_a;
            z_a_reg     <= s_z_a;
            x_b_reg     <= s_x_b;
            y_b_reg     <= s_y_b;
            z_b_reg     <= s_z_b;
            radius0_reg <= s_radius;
        end
        if (stage_load[1]) begin
            mode1_reg   <= mode0_reg;
            radius1_reg <= radius0_reg;
        end
        if (stage_load[2]) begin
            mode2_reg   <= mode1_reg;
            radius2_reg <= radius1_reg;
        end
    end

    fct_plane_file u_plane_file (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .plane     (plane)
    );

    assign lane_en.prod_load = stage_load[1];
    assign lane_en.dist_load = stage_load[2];
    assign is_box            = (mode0_reg == fct_pkg::MODE_BOX);

    for (genvar p = 0; p < fct_pkg::PLANE_COUNT; p++) begin : g_lane
        fct_plane_eval #(
            .COORD_BITS       (COORD_BITS),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_eval (
            .aclk      (aclk),
            .en        (lane_en),
            .plane     (plane[p]),
            .is_box    (is_box),
            .x_a       (x_a_reg),
            .y_a       (y_a_reg),
            .z_a       (z_a_reg),
            .x_b       (x_b_reg),
            .y_b       (y_b_reg),
            .z_b       (z_b_reg),
            .far_dist  (far_dist[p]),
            .near_dist (near_dist[p])
        );
    end

    fct_verdict #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_verdict (
        .aclk      (aclk),
        .load      (stage_load[STAGES-1]),
        .mode      (mode2_reg),
        .radius    (radius2_reg),
        .far_dist  (far_dist),
        .near_dist (near_dist),
        .verdict   (m_verdict)
    );

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[STAGES-1];

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (valid_reg == '1 && !m_ready))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_stage0: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted transaction lost at input register");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict != 2'd3))
        else $error("verdict carries an unused code");

    a_no_drop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[STAGES-2] && valid_reg[STAGES-1] && !m_ready) |=> valid_reg[STAGES-2])
        else $error("distance stage dropped a transaction under stall");

endmodule

`default_nettype wire
